// ----- design/frpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frpc_pkg
// Shared types, constants and the CRC-16 step for the framed packet receiver.
// ----------------------------------------------------------------------------
package frpc_pkg;

   // Default payload buffer size in bytes
   localparam int BUFFER_BYTES_DEF = 256;

   // Register reset values
   localparam logic [7:0]  START_BYTE_RST = 8'hA1;
   localparam logic [7:0]  MAX_LENGTH_RST = 8'd200;

   // Reflected CRC-16 start value
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // Register indexes on the configuration port (paddr[2])
   localparam logic REG_START_BYTE = 1'b0;
   localparam logic REG_MAX_LENGTH = 1'b1;

   // Receiver controller states
   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_TYPE    = 8'b0000_0010,
      ST_LEN     = 8'b0000_0100,
      ST_CRC_LO  = 8'b0000_1000,
      ST_CRC_HI  = 8'b0001_0000,
      ST_PAYLOAD = 8'b0010_0000,
      ST_FETCH   = 8'b0100_0000,
      ST_PRESENT = 8'b1000_0000
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic take_type;
      logic take_len;
      logic take_crc_lo;
      logic take_crc_hi;
      logic take_payload;
      logic start_emit;
      logic fetch;
      logic load_out;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_start;
      logic len_ok;
      logic len_zero;
      logic last_byte;
      logic hdr_crc_ok;
      logic pay_crc_ok;
      logic out_free;
      logic last_word;
   } dp_status_type;

   // One byte of the reflected CRC-16 (polynomial 0x8408)
   function automatic logic [15:0] crc16_step(input logic [7:0] b, input logic [15:0] crc);
      logic [7:0] x;
      x = b ^ crc[7:0];
      x = x ^ {x[3:0], 4'b0000};
      return {x, crc[15:8]} ^ {12'h000, x[7:4]} ^ {5'b00000, x, 3'b000};
   endfunction

endpackage

// ----- design/frpc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frpc_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; hold data when no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/frpc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frpc_ctrl
// Frame parser and readout sequencer for the packet receiver.
// ----------------------------------------------------------------------------
module frpc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  frpc_pkg::dp_status_type status,
   output frpc_pkg::ctrl_cmd_type  cmd
);
   import frpc_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // Stall input while reading out a packet
   assign req_stall = (state_ff == ST_FETCH) || (state_ff == ST_PRESENT);
   assign accept    = req_valid && !req_stall;

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && status.is_start) begin
               state_in = ST_TYPE;
            end
         end
         ST_TYPE: begin
            if (accept) begin
               cmd.take_type = 1'b1;
               state_in      = ST_LEN;
            end
         end
         ST_LEN: begin
            if (accept) begin
               if (status.len_ok) begin
                  cmd.take_len = 1'b1;
                  state_in     = ST_CRC_LO;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CRC_LO: begin
            if (accept) begin
               cmd.take_crc_lo = 1'b1;
               state_in        = ST_CRC_HI;
            end
         end
         ST_CRC_HI: begin
            if (accept) begin
               cmd.take_crc_hi = 1'b1;
               if (!status.len_zero) begin
                  state_in = ST_PAYLOAD;
               end else if (status.hdr_crc_ok) begin
                  cmd.start_emit = 1'b1;
                  state_in       = ST_FETCH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PAYLOAD: begin
            if (accept) begin
               cmd.take_payload = 1'b1;
               if (status.last_byte) begin
                  if (status.pay_crc_ok) begin
                     cmd.start_emit = 1'b1;
                     state_in       = ST_FETCH;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_PRESENT;
         end
         ST_PRESENT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = status.last_word ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/frpc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frpc_dp
// Header registers, CRC, payload word assembly, buffer and result register.
// ----------------------------------------------------------------------------
module frpc_dp #(
   parameter int BUFFER_BYTES = frpc_pkg::BUFFER_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              start_byte,
   input  logic [7:0]              max_length,
   input  logic [7:0]              req_rx_byte,
   input  frpc_pkg::ctrl_cmd_type  cmd,
   output frpc_pkg::dp_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_packet_type,
   output logic [7:0]              rsp_packet_length,
   output logic [4:0]              rsp_word_index,
   output logic [63:0]             rsp_payload_word,
   output logic [3:0]              rsp_valid_bytes,
   output logic                    rsp_last_word
);
   import frpc_pkg::*;

   localparam int WORDS  = (BUFFER_BYTES + 7) / 8;
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [7:0]  type_ff;
   logic [7:0]  length_ff;
   logic [15:0] rcv_crc_ff;
   logic [15:0] run_crc_ff, run_crc_in;
   logic [7:0]  count_ff;
   logic [63:0] asm_ff, asm_in;
   logic [4:0]  k_ff;

   logic        rsp_valid_ff;
   logic [7:0]  out_type_ff;
   logic [7:0]  out_length_ff;
   logic [4:0]  out_index_ff;
   logic [63:0] out_word_ff;
   logic [3:0]  out_vb_ff;
   logic        out_last_ff;

   logic [15:0] crc_next;
   logic [7:0]  count_inc;
   logic [63:0] merged;
   logic        wr_en;
   logic [63:0] rd_data;
   logic [7:0]  len_m1;
   logic [4:0]  last_idx;
   logic [8:0]  remain;
   logic [3:0]  vb;

   // CRC over the current byte
   assign crc_next  = crc16_step(req_rx_byte, run_crc_ff);
   assign count_inc = count_ff + 8'd1;

   // Status toward the controller
   assign status.is_start   = (req_rx_byte == start_byte);
   assign status.len_ok     = (req_rx_byte <= max_length)
                              && ({1'b0, req_rx_byte} <= 9'(BUFFER_BYTES));
   assign status.len_zero   = (length_ff == 8'd0);
   assign status.last_byte  = (count_inc == length_ff);
   assign status.hdr_crc_ok = (run_crc_ff == {req_rx_byte, rcv_crc_ff[7:0]});
   assign status.pay_crc_ok = (crc_next == rcv_crc_ff);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.last_word  = (k_ff == last_idx);

   // Merge the byte into its lane of the word being assembled
   always_comb begin
      merged = asm_ff;
      for (int i = 0; i < 8; i++) begin
         if (count_ff[2:0] == 3'(i)) begin
            merged[8*i +: 8] = req_rx_byte;
         end
      end
   end

   // Write a word when its last lane fills or the payload ends
   assign wr_en  = cmd.take_payload && ((count_ff[2:0] == 3'd7) || status.last_byte);
   assign asm_in = (cmd.take_crc_hi || wr_en) ? 64'd0
                   : (cmd.take_payload ? merged : asm_ff);

   // Running CRC
   always_comb begin
      run_crc_in = run_crc_ff;
      if (cmd.take_type) begin
         run_crc_in = crc16_step(req_rx_byte, CRC_INIT);
      end else if (cmd.take_len || cmd.take_payload) begin
         run_crc_in = crc_next;
      end
   end

   // Header, CRC and payload assembly registers
   always_ff @(posedge clock) begin
      if (cmd.take_type) begin
         type_ff <= req_rx_byte;
      end
      if (cmd.take_len) begin
         length_ff <= req_rx_byte;
      end
      if (cmd.take_crc_lo) begin
         rcv_crc_ff[7:0] <= req_rx_byte;
      end
      if (cmd.take_crc_hi) begin
         rcv_crc_ff[15:8] <= req_rx_byte;
      end
      if (cmd.take_crc_hi) begin
         count_ff <= 8'd0;
      end else if (cmd.take_payload) begin
         count_ff <= count_inc;
      end
      run_crc_ff <= run_crc_in;
      asm_ff     <= asm_in;
   end

   // Payload buffer
   frpc_ram #(
      .WIDTH (64),
      .DEPTH (WORDS),
      .ADDR_W(ADDR_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[ADDR_W+2:3]),
      .wr_data(merged),
      .rd_en  (cmd.fetch),
      .rd_addr(k_ff[ADDR_W-1:0]),
      .rd_data(rd_data)
   );

   // Word count and byte count of the word being read out
   assign len_m1   = length_ff - 8'd1;
   assign last_idx = status.len_zero ? 5'd0 : len_m1[7:3];
   assign remain   = {1'b0, length_ff} - {1'b0, k_ff, 3'b000};
   assign vb       = status.len_zero ? 4'd0
                     : ((remain >= 9'd8) ? 4'd8 : remain[3:0]);

   // Readout word index
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= 5'd0;
      end else if (cmd.start_emit) begin
         k_ff <= 5'd0;
      end else if (cmd.load_out) begin
         k_ff <= k_ff + 5'd1;
      end
   end

   // Result register: load on a free slot, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_type_ff   <= type_ff;
         out_length_ff <= length_ff;
         out_index_ff  <= k_ff;
         out_word_ff   <= (vb == 4'd0) ? 64'd0 : rd_data;
         out_vb_ff     <= vb;
         out_last_ff   <= status.last_word;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_packet_type   = out_type_ff;
   assign rsp_packet_length = out_length_ff;
   assign rsp_word_index    = out_index_ff;
   assign rsp_payload_word  = out_word_ff;
   assign rsp_valid_bytes   = out_vb_ff;
   assign rsp_last_word     = out_last_ff;

endmodule

// ----- design/framed_packet_receiver_crc16_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc16_unit
// Byte-stream frame receiver with CRC-16 check and 64-bit word readout.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per transfer. In idle the receiver waits
//   for the start byte; then it takes type, length, CRC low, CRC high and
//   the payload bytes. A length above max_length or the buffer size drops the
//   frame. After the last byte of a frame whose CRC matches, req_stall rises
//   and the packet is read out of the payload RAM, each result word by a RAM
//   read and then a load of the output register, 1 to 32 words; the input
//   stays held until the last word is loaded. rsp_* presents one word per
//   transfer from an output register; the input resumes while the final word
//   still waits. A stalled receiver freezes the readout and the held word.
//   Frames with a bad CRC are dropped silently.
//   Reset returns the parser to idle, empties the output register and loads
//   start_byte 0xA1 and max_length 200; the payload RAM needs no clearing.
//   csr_*: start_byte at address 0, max_length at address 4.
// ----------------------------------------------------------------------------
module framed_packet_receiver_crc16_unit #(
   parameter int BUFFER_BYTES = frpc_pkg::BUFFER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_packet_type,
   output logic [7:0]  rsp_packet_length,
   output logic [4:0]  rsp_word_index,
   output logic [63:0] rsp_payload_word,
   output logic [3:0]  rsp_valid_bytes,
   output logic        rsp_last_word,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import frpc_pkg::*;

   logic [7:0]    start_byte_ff;
   logic [7:0]    max_length_ff;
   logic          csr_wr;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RST;
         max_length_ff <= MAX_LENGTH_RST;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_START_BYTE) begin
            start_byte_ff <= csr_pwdata[7:0];
         end
         if (csr_paddr[2] == REG_MAX_LENGTH) begin
            max_length_ff <= csr_pwdata[7:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_MAX_LENGTH) ? {24'd0, max_length_ff}
                                                        : {24'd0, start_byte_ff};

   // Controller
   frpc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   // Datapath
   frpc_dp #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .start_byte       (start_byte_ff),
      .max_length       (max_length_ff),
      .req_rx_byte      (req_rx_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_packet_type  (rsp_packet_type),
      .rsp_packet_length(rsp_packet_length),
      .rsp_word_index   (rsp_word_index),
      .rsp_payload_word (rsp_payload_word),
      .rsp_valid_bytes  (rsp_valid_bytes),
      .rsp_last_word    (rsp_last_word)
   );

endmodule

// ----- design/frpc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frpc_checker
// Port-level checks on the packet receiver's result channel.
// ----------------------------------------------------------------------------
module frpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_packet_length,
   input logic [4:0]  rsp_word_index,
   input logic [63:0] rsp_payload_word,
   input logic [3:0]  rsp_valid_bytes,
   input logic        rsp_last_word
);

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_word))
      else $error("stalled result dropped or changed");

   // Empty output after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Final word sits at the packet's last word index
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_word |->
         (rsp_packet_length == 8'd0 && rsp_word_index == 5'd0) ||
         (rsp_packet_length != 8'd0 &&
          rsp_word_index == 5'((rsp_packet_length - 8'd1) >> 3)))
      else $error("last word at wrong index");

   // Only the final word may be partial
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_word |-> rsp_valid_bytes == 4'd8)
      else $error("partial word before the end of the packet");

endmodule

bind framed_packet_receiver_crc16_unit frpc_checker u_frpc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_packet_length(rsp_packet_length),
   .rsp_word_index   (rsp_word_index),
   .rsp_payload_word (rsp_payload_word),
   .rsp_valid_bytes  (rsp_valid_bytes),
   .rsp_last_word    (rsp_last_word)
);

// ----- tb/sv/tb_framed_packet_receiver_crc16_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_packet_receiver_crc16_unit
// Self-checking bench for the framed packet receiver with CRC-16 check.
// A byte-level parser model runs beside the block and queues the packet
// words that each accepted byte should release. Output words are compared
// field by field in arrival order. Traffic starts with directed frames, then
// mixes good frames, bad-CRC frames, oversized lengths and line noise across
// several register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_framed_packet_receiver_crc16_unit;
   import frpc_pkg::*;

   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 80;

   // One expected output word of an accepted packet
   typedef struct {
      logic [7:0]  ptype;
      logic [7:0]  plen;
      logic [4:0]  windex;
      logic [63:0] word;
      logic [3:0]  vbytes;
      logic        last;
   } packet_word_type;

   // Parser model plus the queue of packet words still awaited
   class frame_tracker;
      logic [7:0]   start_byte  = START_BYTE_RST;
      logic [7:0]   max_length  = MAX_LENGTH_RST;
      state_type    parse_state = ST_IDLE;
      logic [7:0]   held_type   = 8'h00;
      logic [7:0]   held_length = 8'h00;
      logic [15:0]  sent_crc    = 16'h0000;
      logic [15:0]  running_crc = CRC_INIT;
      logic [7:0]   byte_count  = 8'h00;
      bit   [63:0]  payload_ram [32];
      packet_word_type awaited_words [$];
      int           words_checked = 0;
      int           errors = 0;

      // Reflected CRC-16, polynomial 0x8408, one bit at a time
      static function logic [15:0] crc16_fold(input logic [7:0] b, input logic [15:0] crc);
         logic [15:0] acc;
         int          i;
         acc = crc ^ {8'h00, b};
         for (i = 0; i < 8; i++)
            acc = acc[0] ? ((acc >> 1) ^ 16'h8408) : (acc >> 1);
         return acc;
      endfunction

      function void set_register(input logic sel, input logic [7:0] value);
         if (sel == REG_START_BYTE)
            start_byte = value;
         else
            max_length = value;
      endfunction

      // Queue the words of the held packet, masking bytes past its length
      function void release_packet();
         packet_word_type w;
         int           n_words;
         int           remain;
         int           k;
         logic [63:0]  mask;
         n_words = (held_length == 0) ? 1 : (int'(held_length) + 7) / 8;
         for (k = 0; k < n_words; k++) begin
            remain = int'(held_length) - 8 * k;
            if (remain < 0)
               remain = 0;
            if (remain > 8)
               remain = 8;
            mask = (remain == 8) ? {64{1'b1}} : ((64'h1 << (remain * 8)) - 64'h1);
            w.ptype  = held_type;
            w.plen   = held_length;
            w.windex = k[4:0];
            w.word   = payload_ram[k] & mask;
            w.vbytes = remain[3:0];
            w.last   = (k + 1 == n_words);
            awaited_words.push_back(w);
         end
      endfunction

      function void close_frame();
         if (running_crc == sent_crc)
            release_packet();
         parse_state = ST_IDLE;
         byte_count  = 8'h00;
      endfunction

      // Advance the parser by one accepted byte
      function void take_byte(input logic [7:0] b);
         case (parse_state)
            ST_TYPE: begin
               held_type   = b;
               running_crc = crc16_fold(b, CRC_INIT);
               parse_state = ST_LEN;
            end
            ST_LEN: begin
               if (b > max_length) begin
                  parse_state = ST_IDLE;
               end else begin
                  held_length = b;
                  running_crc = crc16_fold(b, running_crc);
                  parse_state = ST_CRC_LO;
               end
            end
            ST_CRC_LO: begin
               sent_crc    = {8'h00, b};
               parse_state = ST_CRC_HI;
            end
            ST_CRC_HI: begin
               sent_crc[15:8] = b;
               byte_count     = 8'h00;
               if (held_length == 0)
                  close_frame();
               else
                  parse_state = ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
               payload_ram[byte_count[7:3]][byte_count[2:0] * 8 +: 8] = b;
               running_crc = crc16_fold(b, running_crc);
               byte_count  = byte_count + 8'd1;
               if (byte_count == held_length)
                  close_frame();
            end
            default: begin
               if (b == start_byte) begin
                  parse_state = ST_TYPE;
                  byte_count  = 8'h00;
               end else begin
                  parse_state = ST_IDLE;
               end
            end
         endcase
      endfunction

      function void compare(input string field, input logic [63:0] want,
                            input logic [63:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      // Match one output transfer against the oldest awaited word
      function void check_word(input logic [7:0] ptype, input logic [7:0] plen,
                               input logic [4:0] windex, input logic [63:0] word,
                               input logic [3:0] vbytes, input logic last);
         packet_word_type w;
         if (awaited_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected packet word, expected none, actual type %0h len %0d idx %0d",
                     $time, ptype, plen, windex);
            return;
         end
         w = awaited_words.pop_front();
         words_checked++;
         compare("packet_type", 64'(w.ptype), 64'(ptype));
         compare("packet_length", 64'(w.plen), 64'(plen));
         compare("word_index", 64'(w.windex), 64'(windex));
         compare("payload_word", w.word, word);
         compare("valid_bytes", 64'(w.vbytes), 64'(vbytes));
         compare("last_word", 64'(w.last), 64'(last));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_packet_type;
   logic [7:0]  rsp_packet_length;
   logic [4:0]  rsp_word_index;
   logic [63:0] rsp_payload_word;
   logic [3:0]  rsp_valid_bytes;
   logic        rsp_last_word;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'b000;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   frame_tracker board;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles = 0;
   int bytes_sent = 0;
   int frames_sent = 0;
   int settings_applied = 0;

   framed_packet_receiver_crc16_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_packet_type   (rsp_packet_type),
      .rsp_packet_length (rsp_packet_length),
      .rsp_word_index    (rsp_word_index),
      .rsp_payload_word  (rsp_payload_word),
      .rsp_valid_bytes   (rsp_valid_bytes),
      .rsp_last_word     (rsp_last_word),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99, 0) < rsp_stall_pct);
   end

   // Check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_word(rsp_packet_type, rsp_packet_length, rsp_word_index,
                          rsp_payload_word, rsp_valid_bytes, rsp_last_word);
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one byte after a random gap and hold it until the transfer
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99, 0) < req_idle_pct) begin
         req_valid   <= 1'b0;
         req_rx_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      bytes_sent++;
      board.take_byte(b);
   endtask

   // Send a frame; fill < 0 gives random payload bytes
   task automatic send_frame(input logic [7:0] ptype, input logic [7:0] plen,
                             input bit spoil_crc, input int fill);
      logic [7:0]  body [256];
      logic [15:0] crc;
      int          i;
      frames_sent++;
      send_byte(board.start_byte);
      send_byte(ptype);
      send_byte(plen);
      // oversized length drops the frame right after the length byte
      if (plen > board.max_length)
         return;
      crc = frame_tracker::crc16_fold(ptype, CRC_INIT);
      crc = frame_tracker::crc16_fold(plen, crc);
      for (i = 0; i < plen; i++) begin
         body[i] = (fill < 0) ? 8'($urandom) : fill[7:0];
         crc = frame_tracker::crc16_fold(body[i], crc);
      end
      if (spoil_crc)
         crc = crc ^ (16'h0001 << $urandom_range(15, 0));
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
      for (i = 0; i < plen; i++)
         send_byte(body[i]);
   endtask

   // Mostly short lengths, now and then anything up to the limit
   function automatic logic [7:0] pick_length();
      int cap;
      int short_cap;
      cap = int'(board.max_length);
      short_cap = (cap < 24) ? cap : 24;
      if ($urandom_range(99, 0) < 85)
         return 8'($urandom_range(short_cap, 0));
      return 8'($urandom_range(cap, 0));
   endfunction

   // Random mix of good frames, bad frames, oversized lengths and noise
   task automatic run_traffic(input int budget);
      int         phase_start;
      int         pick;
      int         n;
      int         i;
      logic [7:0] b;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < budget) begin
         pick = $urandom_range(99, 0);
         if (pick < 70) begin
            send_frame(8'($urandom), pick_length(), 1'b0, -1);
         end else if (pick < 80) begin
            send_frame(8'($urandom), pick_length(), 1'b1, -1);
         end else if (pick < 88 && board.max_length != 8'hFF) begin
            send_frame(8'($urandom),
                       8'($urandom_range(255, int'(board.max_length) + 1)), 1'b0, -1);
         end else begin
            n = $urandom_range(4, 1);
            for (i = 0; i < n; i++) begin
               b = 8'($urandom);
               if (i == 0 && $urandom_range(1, 0))
                  b = board.start_byte;
               send_byte(b);
            end
         end
      end
   endtask

   // Walk the parser back to idle, drain results, let the readout finish
   task automatic settle();
      while (board.parse_state != ST_IDLE) begin
         if (board.parse_state == ST_LEN)
            send_byte((board.max_length != 8'hFF) ? 8'hFF : 8'h00);
         else
            send_byte(8'($urandom));
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.awaited_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic sel, input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.set_register(sel, value);
   endtask

   task automatic apply_settings(input logic [7:0] start_value, input logic [7:0] limit);
      write_register(REG_START_BYTE, start_value);
      write_register(REG_MAX_LENGTH, limit);
      settings_applied++;
   endtask

   initial begin
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values, no idling: directed cases first
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(8'h00, 8'd0, 1'b0, -1);
      send_frame(START_BYTE_RST, 8'd2, 1'b0, int'(START_BYTE_RST));
      send_frame(8'h10, MAX_LENGTH_RST + 8'd1, 1'b0, -1);
      send_frame(8'h22, 8'd1, 1'b1, -1);
      send_frame(8'hFF, 8'd9, 1'b0, 255);
      run_traffic(30);
      settle();

      // zero start byte, full length range, slow sender
      apply_settings(8'h00, 8'hFF);
      req_idle_pct = 80;
      send_frame(8'($urandom), 8'd100, 1'b0, -1);
      run_traffic(30);
      settle();

      // all-ones start byte, only empty packets, slow receiver
      apply_settings(8'hFF, 8'h00);
      req_idle_pct  = 0;
      rsp_stall_pct = 80;
      run_traffic(30);
      settle();

      // random mid-range settings, light idling on both sides
      apply_settings(8'($urandom_range(254, 1)), 8'($urandom_range(64, 8)));
      req_idle_pct  = 18;
      rsp_stall_pct = 18;
      run_traffic(30);
      settle();

      $display("Covered %0d bytes in %0d frames across %0d register settings",
               bytes_sent, frames_sent, settings_applied);
      $display("Checked %0d packet words, %0d mismatches", board.words_checked, board.errors);
      if (board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
